/* rtl/core/sfs_pkg.sv */
// shared types and constants for the shift register fifo with search
// used by sfs_ctrl, sfs_datapath and shift_fifo_with_search; no dependencies
package sfs_pkg;

  localparam int DEPTH   = 8;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int FOUND_W = 3;
  localparam int FILL_W  = 4;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SRCH = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic {
    CTRL_READY = 1'b0,
    CTRL_HOLD  = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

/* rtl/core/sfs_ctrl.sv */
// handshake controller: owns the result register state and beat acceptance
// depends on sfs_pkg
module sfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sfs_pkg::dp_cmd_t dp_cmd
);

  sfs_pkg::ctrl_state_t state, state_next;
  logic exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfs_pkg::CTRL_READY;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfs_pkg::CTRL_READY: begin
        if (exec) state_next = sfs_pkg::CTRL_HOLD;
      end
      sfs_pkg::CTRL_HOLD: begin
        if (exec) state_next = sfs_pkg::CTRL_HOLD;
        else if (!rsp_stall) state_next = sfs_pkg::CTRL_READY;
      end
      default: state_next = sfs_pkg::CTRL_READY;
    endcase
  end

  // outputs: a new beat may enter while the held result is being taken
  always_comb begin
    cmd_stall = 1'b0;
    rsp_valid = 1'b0;
    unique case (state)
      sfs_pkg::CTRL_READY: begin
        cmd_stall = 1'b0;
        rsp_valid = 1'b0;
      end
      sfs_pkg::CTRL_HOLD: begin
        cmd_stall = rsp_stall;
        rsp_valid = 1'b1;
      end
      default: begin
        cmd_stall = 1'b0;
        rsp_valid = 1'b0;
      end
    endcase
    exec = cmd_valid && !cmd_stall;
    dp_cmd.exec = exec;
  end

endmodule

/* rtl/core/sfs_datapath.sv */
// slot array, occupancy counter, parallel search and result registers
// depends on sfs_pkg
module sfs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sfs_pkg::dp_cmd_t                  dp_cmd,
  input  logic [1:0]                        command,
  input  logic signed [sfs_pkg::VALUE_W-1:0] value,
  output logic [1:0]                        status,
  output logic signed [sfs_pkg::VALUE_W-1:0] head_value,
  output logic [sfs_pkg::FOUND_W-1:0]       found_slot,
  output logic [sfs_pkg::FILL_W-1:0]        fill_count,
  output logic                              is_empty,
  output logic                              is_full
);

  logic [sfs_pkg::VALUE_W-1:0] slots [sfs_pkg::DEPTH];
  logic [sfs_pkg::VALUE_W-1:0] slots_next [sfs_pkg::DEPTH];
  logic [sfs_pkg::CNT_W-1:0]   occupancy, occupancy_next;

  sfs_pkg::status_t            res_status;
  logic [sfs_pkg::VALUE_W-1:0] res_head;
  logic [sfs_pkg::SLOT_W-1:0]  hit_slot;
  logic                        hit;
  logic                        q_full, q_empty;

  assign q_full  = (occupancy == sfs_pkg::CNT_W'(sfs_pkg::DEPTH));
  assign q_empty = (occupancy == '0);

  // lowest occupied slot that matches
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = sfs_pkg::DEPTH - 1; i >= 0; i--) begin
      if ((sfs_pkg::CNT_W'(i) < occupancy) && (slots[i] == value)) begin
        hit      = 1'b1;
        hit_slot = sfs_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    slots_next     = slots;
    occupancy_next = occupancy;
    res_status     = sfs_pkg::ST_OK;
    res_head       = '0;
    case (command)
      sfs_pkg::CMD_ENQ: begin
        if (q_full) begin
          res_status = sfs_pkg::ST_FULL;
        end else begin
          slots_next[occupancy[sfs_pkg::SLOT_W-1:0]] = value;
          occupancy_next = occupancy + 1'b1;
        end
      end
      sfs_pkg::CMD_DEQ: begin
        if (q_empty) begin
          res_status = sfs_pkg::ST_EMPTY;
        end else begin
          res_head = slots[0];
          for (int i = 0; i < sfs_pkg::DEPTH - 1; i++) begin
            slots_next[i] = slots[i + 1];
          end
          slots_next[sfs_pkg::DEPTH - 1] = '0;
          occupancy_next = occupancy - 1'b1;
        end
      end
      sfs_pkg::CMD_SRCH: begin
        if (!hit) res_status = sfs_pkg::ST_MISS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (dp_cmd.exec) begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      slots      <= slots_next;
      status     <= res_status;
      head_value <= res_head;
      found_slot <= (res_status == sfs_pkg::ST_OK && command == sfs_pkg::CMD_SRCH) ?
                    sfs_pkg::FOUND_W'(hit_slot) : '0;
      fill_count <= sfs_pkg::FILL_W'(occupancy_next);
      is_empty   <= (occupancy_next == '0);
      is_full    <= (occupancy_next == sfs_pkg::CNT_W'(sfs_pkg::DEPTH));
    end
  end

endmodule

/* rtl/core/shift_fifo_with_search.sv */
// shift register fifo with associative search, top level
// the result beat of an accepted command beat is offered from registers in the next cycle
// throughput: one command per cycle while no held result is stalled; compare, shift and write all act on acceptance
// a new command enters while the held result is taken in the same cycle
// reset clears occupancy and the result handshake; slot contents need no reset
module shift_fifo_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [1:0]                        command,
  input  logic signed [sfs_pkg::VALUE_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic signed [sfs_pkg::VALUE_W-1:0] head_value,
  output logic [sfs_pkg::FOUND_W-1:0]       found_slot,
  output logic [sfs_pkg::FILL_W-1:0]        fill_count,
  output logic                              is_empty,
  output logic                              is_full
);

  sfs_pkg::dp_cmd_t dp_cmd;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_cmd    (dp_cmd)
  );

  sfs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .command    (command),
    .value      (value),
    .status     (status),
    .head_value (head_value),
    .found_slot (found_slot),
    .fill_count (fill_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule

/* verif/sfs_result_check.sv */
`timescale 1ns / 100ps
// checker for shift_fifo_with_search: mirrors the queue and search on every command beat
// and compares each result beat with the oldest prediction; depends on sfs_pkg only
module sfs_result_check
  import sfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  logic [1:0]           command,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic [1:0]           status,
  input  logic [VALUE_W-1:0]   head_value,
  input  logic [FOUND_W-1:0]   found_slot,
  input  logic [FILL_W-1:0]    fill_count,
  input  logic                 is_empty,
  input  logic                 is_full,
  output int                   mismatches,
  output int                   replies_due,
  output int                   replies_seen
);

  typedef struct packed {
    status_t              st;
    logic [VALUE_W-1:0]   head;
    logic [FOUND_W-1:0]   slot;
    logic [FILL_W-1:0]    fill;
    logic                 empty;
    logic                 full;
  } fifo_reply_t;

  logic [VALUE_W-1:0] shadow_slots [DEPTH];
  int unsigned        shadow_fill;
  fifo_reply_t        due_replies[$];
  int                 err_tally;
  int                 seen_tally;

  initial begin
    mismatches   = 0;
    replies_due  = 0;
    replies_seen = 0;
    err_tally    = 0;
    seen_tally   = 0;
    shadow_fill  = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
  end

  always @(posedge clk) begin : watch
    fifo_reply_t want;
    fifo_reply_t got;
    if (rst) begin
      due_replies.delete();
      shadow_fill = 0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
    end else begin
      // result beat first: it always belongs to an older command
      if (rsp_valid && !rsp_stall) begin
        seen_tally++;
        got = '{status_t'(status), head_value, found_slot, fill_count, is_empty, is_full};
        if (due_replies.size() == 0) begin
          err_tally++;
          if (err_tally <= 10)
            $display("%0t: result beat with nothing expected: st=%0d head=%h slot=%0d fill=%0d",
                     $time, status, head_value, found_slot, fill_count);
        end else begin
          want = due_replies.pop_front();
          if (got.st !== want.st || got.head !== want.head || got.slot !== want.slot ||
              got.fill !== want.fill || got.empty !== want.empty || got.full !== want.full) begin
            err_tally++;
            if (err_tally <= 10) begin
              $display("%0t: mismatch expected st=%0d head=%h slot=%0d fill=%0d empty=%b full=%b",
                       $time, want.st, want.head, want.slot, want.fill, want.empty, want.full);
              $display("%0t:          actual   st=%0d head=%h slot=%0d fill=%0d empty=%b full=%b",
                       $time, got.st, got.head, got.slot, got.fill, got.empty, got.full);
            end
          end
        end
      end

      if (cmd_valid && !cmd_stall) begin
        want = '{ST_OK, '0, '0, '0, 1'b0, 1'b0};
        case (cmd_t'(command))
          CMD_ENQ: begin
            if (shadow_fill >= DEPTH) want.st = ST_FULL;
            else begin
              shadow_slots[shadow_fill] = value;
              shadow_fill++;
            end
          end
          CMD_DEQ: begin
            if (shadow_fill == 0) want.st = ST_EMPTY;
            else begin
              want.head = shadow_slots[0];
              for (int i = 0; i < DEPTH - 1; i++) shadow_slots[i] = shadow_slots[i + 1];
              shadow_slots[DEPTH - 1] = '0;
              shadow_fill--;
            end
          end
          CMD_SRCH: begin
            // only occupied slots take part; lowest hit wins
            want.st = ST_MISS;
            for (int i = 0; i < shadow_fill; i++) begin
              if (want.st == ST_MISS && shadow_slots[i] == value) begin
                want.st   = ST_OK;
                want.slot = i[FOUND_W-1:0];
              end
            end
          end
          default: ;
        endcase
        want.fill  = shadow_fill[FILL_W-1:0];
        want.empty = (shadow_fill == 0);
        want.full  = (shadow_fill >= DEPTH);
        due_replies.push_back(want);
      end
    end
    mismatches   <= err_tally;
    replies_due  <= due_replies.size();
    replies_seen <= seen_tally;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// top of the shift_fifo_with_search testbench: clock, reset, command stimulus, result stall
// pattern and verdict; uses sfs_pkg, the block and sfs_result_check
module tb_top;
  import sfs_pkg::*;

  localparam int RANDOM_CMDS = 450;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cmd_valid  = 1'b0;
  logic [1:0]         command    = CMD_NOP;
  logic [VALUE_W-1:0] value      = '0;
  logic               rsp_stall  = 1'b0;
  logic               cmd_stall;
  logic               rsp_valid;
  logic [1:0]         status;
  logic [VALUE_W-1:0] head_value;
  logic [FOUND_W-1:0] found_slot;
  logic [FILL_W-1:0]  fill_count;
  logic               is_empty;
  logic               is_full;

  int mismatches;
  int replies_due;
  int replies_seen;
  int cmd_tally [4];
  int cycle_cnt  = 0;
  int stall_mode = 0;
  int mode_left  = 0;

  logic [VALUE_W-1:0] value_pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                         32'hffff_ffff, 32'h0000_0001, 32'h5a5a_5a5a};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shift_fifo_with_search dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .head_value (head_value),
    .found_slot (found_slot),
    .fill_count (fill_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  sfs_result_check checker_i (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .head_value   (head_value),
    .found_slot   (found_slot),
    .fill_count   (fill_count),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .mismatches   (mismatches),
    .replies_due  (replies_due),
    .replies_seen (replies_seen)
  );

  // receiver stall: modes of random length, from never stalling to heavy back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 99) < 30);
        2: rsp_stall <= ($urandom_range(0, 99) < 75);
        default: rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, replies_due);
      $display("status: fail");
      $finish;
    end
  end

  // one command beat; payload holds until it is taken
  task automatic issue(input cmd_t op, input logic [VALUE_W-1:0] v);
    cmd_valid <= 1'b1;
    command   <= op;
    value     <= v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    cmd_tally[op]++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  initial begin : stimulus
    int   burst_left;
    int   phase_left;
    int   bias;
    int   roll;
    cmd_t op;

    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corner cases
    issue(CMD_SRCH, 32'h0000_0000);
    issue(CMD_DEQ,  32'h1234_5678);
    issue(CMD_NOP,  32'hffff_ffff);
    // fill to the top with extremes and a duplicate
    issue(CMD_ENQ, 32'h8000_0000);
    issue(CMD_ENQ, 32'h7fff_ffff);
    issue(CMD_ENQ, 32'h0000_0000);
    issue(CMD_ENQ, 32'hffff_ffff);
    issue(CMD_ENQ, 32'h8000_0000);
    issue(CMD_ENQ, 32'h0000_0001);
    issue(CMD_ENQ, 32'haaaa_aaaa);
    issue(CMD_ENQ, 32'h5555_5555);
    issue(CMD_ENQ, 32'hdead_beef);
    issue(CMD_SRCH, 32'h8000_0000);
    issue(CMD_SRCH, 32'h5555_5555);
    issue(CMD_SRCH, 32'h1234_5678);
    issue(CMD_NOP,  32'h0000_0000);
    // dequeue from a full queue, then check vacated zero slots never match
    issue(CMD_DEQ, 32'h0000_0000);
    issue(CMD_DEQ, 32'h0000_0000);
    issue(CMD_DEQ, 32'h0000_0000);
    issue(CMD_SRCH, 32'h0000_0000);
    issue(CMD_SRCH, 32'h8000_0000);

    burst_left = $urandom_range(1, 20);
    phase_left = 0;
    bias       = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // phases lean toward filling, draining or a mix so full and empty both get hit
      if (phase_left == 0) begin
        bias       = $urandom_range(0, 2);
        phase_left = $urandom_range(15, 60);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (bias)
        0: op = (roll < 55) ? CMD_ENQ : (roll < 70) ? CMD_DEQ : (roll < 95) ? CMD_SRCH : CMD_NOP;
        1: op = (roll < 15) ? CMD_ENQ : (roll < 65) ? CMD_DEQ : (roll < 95) ? CMD_SRCH : CMD_NOP;
        default:
          op = (roll < 35) ? CMD_ENQ : (roll < 65) ? CMD_DEQ : (roll < 93) ? CMD_SRCH : CMD_NOP;
      endcase
      issue(op, pick_value());
      burst_left--;
      if (burst_left == 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
    end
    cmd_valid <= 1'b0;

    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("commands sent: %0d enqueue, %0d dequeue, %0d search, %0d no-op",
             cmd_tally[CMD_ENQ], cmd_tally[CMD_DEQ], cmd_tally[CMD_SRCH], cmd_tally[CMD_NOP]);
    $display("result beats compared: %0d, mismatches: %0d", replies_seen, mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sfs_pkg.sv
rtl/core/sfs_ctrl.sv
rtl/core/sfs_datapath.sv
rtl/core/shift_fifo_with_search.sv
verif/sfs_result_check.sv
verif/tb_top.sv
